// File: rtl/lpu_pkg.sv
`timescale 1ns / 1ps
// lpu_pkg: shared types and constants of the polyphase lanczos line upsampler
// no dependencies

package lpu_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned WIN_DEPTH = 16;
  localparam int unsigned WIN_AW    = 4;
  localparam int unsigned PHASE_W   = 4;
  localparam int unsigned S_W       = 5;
  localparam int unsigned A_W       = 4;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned ACC_W     = 36;

  localparam logic [S_W-1:0] S_LOW  = 5'd2;
  localparam logic [S_W-1:0] S_HIGH = 5'd16;
  localparam logic [A_W-1:0] A_LOW  = 4'd3;
  localparam logic [A_W-1:0] A_HIGH = 4'd8;

  localparam int unsigned ROUND_SHIFT = 14;

  typedef enum logic [1:0] {
    CMD_COEF   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_DRAIN  = 2'd2,
    CMD_NONE   = 2'd3
  } lpu_cmd_e;

  typedef enum logic {
    REG_UPSAMPLE = 1'b0,
    REG_HALF_W   = 1'b1
  } lpu_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_TAP,
    ST_FLUSH
  } lpu_state_e;

  typedef struct packed {
    logic clear;
    logic valid;
  } lpu_mac_ctl_t;

endpackage

// File: rtl/lpu_if.sv
`timescale 1ns / 1ps
// lpu_if: valid/ready channels of the upsampler (items, results, register writes)
// no dependencies

interface lpu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic               line_start;
  logic signed [15:0] sample_value;
  logic [3:0]         coef_phase;
  logic [3:0]         coef_tap;
  logic signed [15:0] coef_value;

  modport source (output valid, command, line_start, sample_value, coef_phase, coef_tap,
                  coef_value, input ready);
  modport sink (input valid, command, line_start, sample_value, coef_phase, coef_tap,
                coef_value, output ready);
endinterface

interface lpu_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_value;
  logic               last_of_group;

  modport source (output valid, out_value, last_of_group, input ready);
  modport sink (input valid, out_value, last_of_group, output ready);
endinterface

interface lpu_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [4:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/lpu_mac.sv
`timescale 1ns / 1ps
// lpu_mac: shared multiply-accumulate with round half up and 16 bit saturation
// depends on lpu_pkg

module lpu_mac (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lpu_pkg::lpu_mac_ctl_t      ctl_i,
  input  logic signed [15:0]         sample_i,
  input  logic signed [15:0]         coef_i,
  output logic                       busy_o,
  output logic signed [15:0]         result_o
);
  import lpu_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic                     pv_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W:0]    biased;
  logic signed [ACC_W-ROUND_SHIFT:0] shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      pv_q <= ctl_i.valid;
      if (ctl_i.clear) begin
        acc_q <= '0;
      end else if (pv_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      prod_q <= sample_i * coef_i;
    end
  end

  always_comb begin
    biased  = (ACC_W+1)'(acc_q) + (ACC_W+1)'(signed'(15'sd8192));
    shifted = (ACC_W-ROUND_SHIFT+1)'(biased >>> ROUND_SHIFT);
    if (shifted > (ACC_W-ROUND_SHIFT+1)'(signed'(17'sd32767))) begin
      result_o = 16'sh7FFF;
    end else if (shifted < (ACC_W-ROUND_SHIFT+1)'(signed'(-17'sd32768))) begin
      result_o = 16'sh8000;
    end else begin
      result_o = shifted[15:0];
    end
  end

  assign busy_o = pv_q;

endmodule

// File: rtl/lanczos_polyphase_upsampler_core.sv
`timescale 1ns / 1ps
// lanczos_polyphase_upsampler_core: top level of the polyphase lanczos line upsampler
// depends on lpu_pkg, lpu_if and lpu_mac

// Upsamples one image line by the factor S with a host-loaded table of Q2.14
// coefficients (phase row times tap slot), mirroring half-sample symmetrically at
// the line ends. A coefficient write or an item that yields no result leaves the
// block idle. A sample or drain item that opens a group first folds the first tap
// position into the mirror period, then produces its up to S results one after
// another: every tap passes one at a time through a single multiply-accumulate
// unit fed by the registered coefficient memory read, and the pipeline empties
// before each result goes to the output register. The block takes no new item
// until the last result of a group is in the output register.

module lanczos_polyphase_upsampler_core #(
  parameter int unsigned MAX_PHASES = 16,
  parameter int unsigned TAP_SLOTS  = 16,
  parameter int unsigned MAX_LINE   = 4096
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  lpu_in_if.sink   item_i,
  lpu_out_if.source result_o,
  lpu_cfg_if.sink  cfg_i
);
  import lpu_pkg::*;

  localparam int unsigned LW    = $clog2(MAX_LINE + 1);
  localparam int unsigned SW    = LW + 2;
  localparam int unsigned TW    = $clog2(TAP_SLOTS);
  localparam int unsigned DEPTH = MAX_PHASES * TAP_SLOTS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [S_W-1:0] S_CAP = S_W'(MAX_PHASES);
  localparam logic [A_W-1:0] A_CAP = A_W'(TAP_SLOTS / 2);

  lpu_state_e state_q, state_d;
  logic [S_W-1:0] s_q;
  logic [A_W-1:0] a_q;
  logic [LW-1:0] seen_q, seen_d;
  logic [A_W-1:0] drains_q, drains_d;
  logic [LW-1:0] len_q, len_d;
  logic signed [SW-1:0] r_q, r_d, rs_q, rs_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [TW-1:0] t_q, t_d;
  logic v1_q;
  logic out_valid_q, out_valid_d;
  logic signed [15:0] out_value_q;
  logic out_last_q;
  logic signed [15:0] samp_q, coef_rd_q;
  logic [15:0] win_q [WIN_DEPTH];
  logic [15:0] coef_mem [DEPTH];

  logic [S_W-1:0] s_eff;
  logic [A_W-1:0] a_eff;
  logic signed [SW-1:0] a_s, m_s, len_s;
  logic [LW-1:0] seen0, len_n;
  logic [A_W-1:0] dr0;
  logic signed [SW-1:0] b_n, ln_s;
  logic go_grp;
  logic win_we;
  logic coef_we;
  logic [AW-1:0] coef_wa, coef_ra;
  logic issue, load_out;
  logic signed [SW-1:0] p_s;
  logic [WIN_AW-1:0] win_ra;
  logic [CNT_W-1:0] tap_last;
  logic [PHASE_W:0] phase_inc;
  lpu_mac_ctl_t mac_ctl;
  logic mac_busy;
  logic signed [15:0] mac_res;

  always_comb begin
    s_eff = s_q;
    if (s_eff < S_LOW) s_eff = S_LOW;
    if (s_eff > S_HIGH) s_eff = S_HIGH;
    if (s_eff > S_CAP) s_eff = S_CAP;
    a_eff = a_q;
    if (a_eff < A_LOW) a_eff = A_LOW;
    if (a_eff > A_HIGH) a_eff = A_HIGH;
    if (a_eff > A_CAP) a_eff = A_CAP;
  end

  assign a_s      = signed'(SW'(a_eff));
  assign m_s      = signed'({1'b0, len_q, 1'b0});
  assign len_s    = signed'({2'b00, len_q});
  assign p_s      = (r_q < len_s) ? r_q : (m_s - r_q - SW'(1));
  assign win_ra   = p_s[WIN_AW-1:0];
  assign coef_ra  = AW'(phase_q) * AW'(TAP_SLOTS) + AW'(t_q);
  assign coef_wa  = AW'(item_i.coef_phase) * AW'(TAP_SLOTS) + AW'(item_i.coef_tap);
  assign tap_last = {a_eff, 1'b0} - CNT_W'(1);
  assign phase_inc = {1'b0, phase_q} + (PHASE_W+1)'(1);

  assign item_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign result_o.valid         = out_valid_q;
  assign result_o.out_value     = out_value_q;
  assign result_o.last_of_group = out_last_q;

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    seen_d      = seen_q;
    drains_d    = drains_q;
    len_d       = len_q;
    r_d         = r_q;
    rs_d        = rs_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    t_d         = t_q;
    go_grp      = 1'b0;
    win_we      = 1'b0;
    coef_we     = 1'b0;
    issue       = 1'b0;
    load_out    = 1'b0;
    seen0       = item_i.line_start ? '0 : seen_q;
    dr0         = item_i.line_start ? '0 : drains_q;
    len_n       = seen_q;
    b_n         = '0;
    ln_s        = '0;
    out_valid_d = out_valid_q && !result_o.ready;

    case (state_q)
      ST_IDLE: begin
        if (item_i.valid) begin
          case (lpu_cmd_e'(item_i.command))
            CMD_COEF: begin
              coef_we = (int'(item_i.coef_phase) < MAX_PHASES) &&
                        (int'(item_i.coef_tap) < TAP_SLOTS);
            end
            CMD_SAMPLE: begin
              seen_d   = seen0;
              drains_d = dr0;
              if (dr0 == '0 && seen0 < LW'(MAX_LINE)) begin
                win_we = 1'b1;
                len_n  = seen0 + LW'(1);
                seen_d = len_n;
                b_n    = signed'({2'b00, seen0}) - a_s;
                go_grp = (b_n >= -SW'(1)) ? 1'b1 : 1'b0;
              end
            end
            CMD_DRAIN: begin
              if (seen_q != '0 && drains_q < a_eff) begin
                drains_d = drains_q + A_W'(1);
                len_n    = seen_q;
                b_n      = signed'({2'b00, seen_q}) - a_s + signed'(SW'(drains_q));
                go_grp   = (b_n >= -SW'(1)) ? 1'b1 : 1'b0;
              end
            end
            default: begin
            end
          endcase
          if (go_grp) begin
            ln_s  = signed'({2'b00, len_n});
            len_d = len_n;
            r_d   = b_n - a_s + SW'(1);
            state_d = ST_NORM;
            if (b_n == -SW'(1)) begin
              cnt_d   = CNT_W'(s_eff >> 1);
              phase_d = '0;
            end else if (b_n == ln_s - SW'(1)) begin
              cnt_d   = CNT_W'(s_eff - (s_eff >> 1));
              phase_d = PHASE_W'(s_eff >> 1);
            end else begin
              cnt_d   = CNT_W'(s_eff);
              phase_d = PHASE_W'(s_eff >> 1);
            end
          end
        end
      end
      ST_NORM: begin
        if (r_q < 0) begin
          r_d = r_q + m_s;
        end else if (r_q >= m_s) begin
          r_d = r_q - m_s;
        end else begin
          rs_d    = r_q;
          t_d     = '0;
          state_d = ST_TAP;
        end
      end
      ST_TAP: begin
        issue = 1'b1;
        r_d   = (r_q + SW'(1) == m_s) ? '0 : r_q + SW'(1);
        t_d   = t_q + TW'(1);
        if (CNT_W'(t_q) == tap_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!v1_q && !mac_busy && (!out_valid_q || result_o.ready)) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          cnt_d       = cnt_q - CNT_W'(1);
          phase_d     = (phase_inc == (PHASE_W+1)'(s_eff)) ? '0 : phase_inc[PHASE_W-1:0];
          r_d         = rs_q;
          t_d         = '0;
          state_d     = (cnt_q == CNT_W'(1)) ? ST_IDLE : ST_TAP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      s_q         <= S_LOW;
      a_q         <= A_LOW;
      seen_q      <= '0;
      drains_q    <= '0;
      len_q       <= '0;
      r_q         <= '0;
      rs_q        <= '0;
      phase_q     <= '0;
      cnt_q       <= '0;
      t_q         <= '0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      drains_q    <= drains_d;
      len_q       <= len_d;
      r_q         <= r_d;
      rs_q        <= rs_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      t_q         <= t_d;
      v1_q        <= issue;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        case (lpu_reg_e'(cfg_i.index))
          REG_UPSAMPLE: s_q <= cfg_i.data;
          REG_HALF_W:   a_q <= cfg_i.data[A_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // sample window, zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_q[i] <= '0;
      end
    end else if (win_we) begin
      win_q[seen0[WIN_AW-1:0]] <= item_i.sample_value;
    end
  end

  // coefficient memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= item_i.coef_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      coef_rd_q <= coef_mem[coef_ra];
      samp_q    <= win_q[win_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_value_q <= mac_res;
      out_last_q  <= (cnt_q == CNT_W'(1));
    end
  end

  assign mac_ctl.clear = issue && (t_q == '0);
  assign mac_ctl.valid = v1_q;

  lpu_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .sample_i (samp_q),
    .coef_i   (coef_rd_q),
    .busy_o   (mac_busy),
    .result_o (mac_res)
  );

endmodule
